### rtl/core/lrta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrta_pkg
// Shared widths, constants, register indexes and pipeline payload types for
// the lapse-rate temperature adjust unit.
// ----------------------------------------------------------------------------
package lrta_pkg;

    // field widths
    localparam int TEMP_W     = 17;   // temperature, 1/256 K
    localparam int HGT_W      = 20;   // height, 1/16 m
    localparam int RATE_W     = 22;   // lapse rate, 2^-24 K/m
    localparam int OFF_W      = 15;   // height offset, 1/16 m
    localparam int DZ_W       = HGT_W + 1;
    localparam int DT_W       = TEMP_W + 1;
    localparam int DH_W       = HGT_W + 2;
    localparam int DEN_W      = HGT_W;     // |dz| magnitude
    localparam int QUO_W      = RATE_W - 1; // quotient magnitude bits
    localparam int PROD_W     = RATE_W + DH_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FRAC_SH    = 20;
    localparam int RES_W      = SUM_W - FRAC_SH;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RATE_W;

    // constants
    localparam logic [QUO_W-1:0]  RATE_SAT     = QUO_W'(1677722);   // 0.1 K/m
    localparam logic [TEMP_W-1:0] TEMP_MAX     = TEMP_W'(102400);   // 400 K
    localparam logic signed [DZ_W-1:0] MIN_SPACING = DZ_W'(16);     // 1 m
    localparam logic [RATE_W-1:0] RATE_DEFAULT = RATE_W'(109052);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_MODE    = 3'd0,
        CFG_CONST_RATE    = 3'd1,
        CFG_FALLBACK_RATE = 3'd2,
        CFG_BOUNDS_EN     = 3'd3,
        CFG_MIN_BOUND     = 3'd4,
        CFG_MAX_BOUND     = 3'd5,
        CFG_HEIGHT_OFFSET = 3'd6
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic                     local_mode;
        logic signed [RATE_W-1:0] const_rate;
        logic signed [RATE_W-1:0] fallback_rate;
        logic                     bounds_en;
        logic signed [RATE_W-1:0] min_bound;
        logic signed [RATE_W-1:0] max_bound;
        logic signed [OFF_W-1:0]  height_offset;
    } t_cfg;

    // divider state carried from cell to cell
    typedef struct packed {
        logic [DEN_W-1:0] rem;   // partial remainder
        logic [DEN_W-1:0] den;   // |dz|
        logic [QUO_W-1:0] quo;   // quotient bits so far
        logic             nbit;  // next numerator bit to shift in
    } t_div;

    // per-beat payload riding alongside the divider
    typedef struct packed {
        logic [TEMP_W-1:0]      obs;
        logic signed [DH_W-1:0] dh;     // station minus adjusted model height
        logic                   ok;     // all required values present
        logic                   narrow; // level spacing under 1 m
        logic                   ovf;    // quotient beyond the rate range
        logic                   neg;    // quotient sign
    } t_side;

endpackage

### rtl/core/lrta_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrta_prep
// Entry stage: forms height and temperature differences, validity, and the
// seed of the long division for the local lapse rate.
// ----------------------------------------------------------------------------
module lrta_prep (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  lrta_pkg::t_cfg                     i_cfg,
    input  logic                               i_valid,
    input  logic [lrta_pkg::TEMP_W-1:0]        i_obs_temperature,
    input  logic                               i_obs_valid,
    input  logic signed [lrta_pkg::HGT_W-1:0]  i_station_height,
    input  logic                               i_station_valid,
    input  logic signed [lrta_pkg::HGT_W-1:0]  i_model_height,
    input  logic                               i_model_valid,
    input  logic [lrta_pkg::TEMP_W-1:0]        i_lower_level_temp,
    input  logic [lrta_pkg::TEMP_W-1:0]        i_upper_level_temp,
    input  logic signed [lrta_pkg::HGT_W-1:0]  i_lower_level_height,
    input  logic signed [lrta_pkg::HGT_W-1:0]  i_upper_level_height,
    input  logic                               i_profile_valid,
    output logic                               o_valid,
    output lrta_pkg::t_div                     o_div,
    output lrta_pkg::t_side                    o_side
);
    import lrta_pkg::*;

    logic signed [DZ_W-1:0]   w_dz;
    logic signed [DT_W-1:0]   w_dt;
    logic signed [DZ_W-1:0]   w_mdl_adj;
    logic [DZ_W-1:0]          w_dz_abs;
    logic [DT_W-1:0]          w_dt_abs;
    logic [TEMP_W-1:0]        w_num;
    logic [DEN_W-1:0]         w_den;
    t_div                     n_div;
    t_side                    n_side;
    logic                     r_valid;
    t_div                     r_div;
    t_side                    r_side;

    // differences and magnitudes
    always_comb begin
        w_dz      = DZ_W'(i_upper_level_height) - DZ_W'(i_lower_level_height);
        w_dt      = $signed({1'b0, i_lower_level_temp}) - $signed({1'b0, i_upper_level_temp});
        w_mdl_adj = DZ_W'(i_model_height) + DZ_W'(i_cfg.height_offset);
        w_dz_abs  = w_dz[DZ_W-1] ? DZ_W'(-w_dz) : w_dz;
        w_dt_abs  = w_dt[DT_W-1] ? DT_W'(-w_dt) : w_dt;
        w_num     = w_dt_abs[TEMP_W-1:0];
        w_den     = w_dz_abs[DEN_W-1:0];
    end

    // division seed: remainder starts at |dT|/2, first shifted bit is |dT| lsb
    always_comb begin
        n_div.rem  = DEN_W'(w_num >> 1);
        n_div.den  = w_den;
        n_div.quo  = '0;
        n_div.nbit = w_num[0];

        n_side.obs    = i_obs_temperature;
        n_side.dh     = DH_W'(i_station_height) - DH_W'(w_mdl_adj);
        n_side.ok     = i_obs_valid && i_station_valid && i_model_valid
                        && (!i_cfg.local_mode || i_profile_valid);
        n_side.narrow = (w_dz > -MIN_SPACING) && (w_dz < MIN_SPACING);
        // quotient >= 2^QUO_W when |dT| * 2^20 >= |dz| * 2^21
        n_side.ovf    = {(DEN_W + 1 - TEMP_W)'(0), w_num} >= {w_den, 1'b0};
        n_side.neg    = w_dt[DT_W-1] ^ w_dz[DZ_W-1];
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_div  <= n_div;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

### rtl/core/lrta_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrta_div_cell
// One restoring-division cell: resolves one quotient bit per beat and hands
// the remainder and the riding payload to the next cell.
// ----------------------------------------------------------------------------
module lrta_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  lrta_pkg::t_div  i_div,
    input  lrta_pkg::t_side i_side,
    output logic            o_valid,
    output lrta_pkg::t_div  o_div,
    output lrta_pkg::t_side o_side
);
    import lrta_pkg::*;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W+1:0] w_diff;
    logic             w_qbit;
    t_div             n_div;
    logic             r_valid;
    t_div             r_div;
    t_side            r_side;

    // shift in one numerator bit, trial subtract
    always_comb begin
        w_shift    = {i_div.rem, i_div.nbit};
        w_diff     = {1'b0, w_shift} - {2'b00, i_div.den};
        w_qbit     = !w_diff[DEN_W+1];
        n_div.rem  = w_qbit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        n_div.den  = i_div.den;
        n_div.quo  = {i_div.quo[QUO_W-2:0], w_qbit};
        n_div.nbit = 1'b0;   // low numerator bits are all zero
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

### rtl/core/lrta_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrta_tail
// Rate selection and clamping, height correction product, rounding sum and
// saturation into the output register.
// ----------------------------------------------------------------------------
module lrta_tail (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  lrta_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    input  lrta_pkg::t_div               i_div,
    input  lrta_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [lrta_pkg::TEMP_W-1:0]  o_adjusted_temperature,
    output logic                         o_result_valid
);
    import lrta_pkg::*;

    logic [QUO_W-1:0]          w_mag;
    logic signed [RATE_W-1:0]  w_qrate;
    logic signed [RATE_W-1:0]  w_lrate;
    logic signed [RATE_W-1:0]  w_hi_cl;
    logic signed [RATE_W-1:0]  n_rate;
    logic signed [SUM_W-1:0]   n_sum;
    logic [RES_W-1:0]          w_res;
    logic [TEMP_W-1:0]         n_temp;

    logic                      r_v_rate, r_v_prod, r_v_sum, r_v_out;
    logic signed [RATE_W-1:0]  r_rate;
    logic signed [DH_W-1:0]    r_dh_r;
    logic [TEMP_W-1:0]         r_obs_r, r_obs_p;
    logic                      r_ok_r, r_ok_p, r_ok_s, r_ok_o;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_sum;
    logic [TEMP_W-1:0]         r_temp;

    // lapse rate: constant rate, or quotient saturation, fallback, bounds
    always_comb begin
        w_mag   = (i_side.ovf || (i_div.quo > RATE_SAT)) ? RATE_SAT : i_div.quo;
        w_qrate = i_side.neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        w_lrate = i_side.narrow ? i_cfg.fallback_rate : w_qrate;
        w_hi_cl = (w_lrate > i_cfg.max_bound) ? i_cfg.max_bound : w_lrate;
        if (!i_cfg.local_mode) begin
            n_rate = i_cfg.const_rate;
        end else if (i_cfg.bounds_en) begin
            n_rate = (w_hi_cl < i_cfg.min_bound) ? i_cfg.min_bound : w_hi_cl;
        end else begin
            n_rate = w_lrate;
        end
    end

    // rounding sum: obs * 2^20 + rate * dh + half lsb
    always_comb begin
        n_sum = $signed({(SUM_W - TEMP_W - FRAC_SH)'(0), r_obs_p, FRAC_SH'(0)})
                + SUM_W'(r_prod)
                + $signed(SUM_W'(1) <<< (FRAC_SH - 1));
    end

    // saturate to 0..400 K, zero when invalid
    always_comb begin
        w_res = r_sum[SUM_W-1:FRAC_SH];
        if (!r_ok_s || r_sum[SUM_W-1]) begin
            n_temp = '0;
        end else if (w_res > RES_W'(TEMP_MAX)) begin
            n_temp = TEMP_MAX;
        end else begin
            n_temp = w_res[TEMP_W-1:0];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rate <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else if (i_adv) begin
            r_v_rate <= i_valid;
            r_v_prod <= r_v_rate;
            r_v_sum  <= r_v_prod;
            r_v_out  <= r_v_sum;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rate  <= n_rate;
            r_dh_r  <= i_side.dh;
            r_obs_r <= i_side.obs;
            r_ok_r  <= i_side.ok;

            r_prod  <= r_rate * r_dh_r;
            r_obs_p <= r_obs_r;
            r_ok_p  <= r_ok_r;

            r_sum   <= n_sum;
            r_ok_s  <= r_ok_p;

            r_temp  <= n_temp;
            r_ok_o  <= r_ok_s;
        end
    end

    assign o_valid                = r_v_out;
    assign o_adjusted_temperature = r_temp;
    assign o_result_valid         = r_ok_o;

endmodule

### rtl/core/lapse_rate_temperature_adjust_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapse_rate_temperature_adjust_unit
// Corrects an observed air temperature to model height using a constant or
// locally derived lapse rate, one observation location per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one location per beat;
//   output channel o_out_valid / i_out_stall returns one result per beat.
//   26 register stages, the first loaded at the accepting edge: an entry
//   stage, a row of 21 division cells (one quotient bit each) for the local
//   rate, then rate select, multiply, rounding sum and output register.
//   One beat is accepted every cycle while the output is not stalled; the
//   division cell row sets the depth, not the rate. A stalled result holds
//   in the output register and the whole pipeline freezes with it;
//   o_in_stall is raised for exactly those cycles. Reset (synchronous,
//   active low) empties the pipeline and loads the register defaults.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write them only while no beat is in flight, as the block
//   itself does not enforce this.
// ----------------------------------------------------------------------------
module lapse_rate_temperature_adjust_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [lrta_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lrta_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [lrta_pkg::TEMP_W-1:0]           i_obs_temperature,
    input  logic                                  i_obs_valid,
    input  logic signed [lrta_pkg::HGT_W-1:0]     i_station_height,
    input  logic                                  i_station_valid,
    input  logic signed [lrta_pkg::HGT_W-1:0]     i_model_height,
    input  logic                                  i_model_valid,
    input  logic [lrta_pkg::TEMP_W-1:0]           i_lower_level_temp,
    input  logic [lrta_pkg::TEMP_W-1:0]           i_upper_level_temp,
    input  logic signed [lrta_pkg::HGT_W-1:0]     i_lower_level_height,
    input  logic signed [lrta_pkg::HGT_W-1:0]     i_upper_level_height,
    input  logic                                  i_profile_valid,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [lrta_pkg::TEMP_W-1:0]           o_adjusted_temperature,
    output logic                                  o_result_valid
);
    import lrta_pkg::*;

    t_cfg   r_cfg;
    logic   w_adv;
    logic   w_valid [0:QUO_W];
    t_div   w_div   [0:QUO_W];
    t_side  w_side  [0:QUO_W];

    // pipeline moves unless a finished result is held back
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_mode    <= 1'b0;
            r_cfg.const_rate    <= RATE_DEFAULT;
            r_cfg.fallback_rate <= RATE_DEFAULT;
            r_cfg.bounds_en     <= 1'b0;
            r_cfg.min_bound     <= '0;
            r_cfg.max_bound     <= '0;
            r_cfg.height_offset <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LOCAL_MODE:    r_cfg.local_mode    <= i_cfg_data[0];
                CFG_CONST_RATE:    r_cfg.const_rate    <= i_cfg_data[RATE_W-1:0];
                CFG_FALLBACK_RATE: r_cfg.fallback_rate <= i_cfg_data[RATE_W-1:0];
                CFG_BOUNDS_EN:     r_cfg.bounds_en     <= i_cfg_data[0];
                CFG_MIN_BOUND:     r_cfg.min_bound     <= i_cfg_data[RATE_W-1:0];
                CFG_MAX_BOUND:     r_cfg.max_bound     <= i_cfg_data[RATE_W-1:0];
                CFG_HEIGHT_OFFSET: r_cfg.height_offset <= i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // entry stage
    lrta_prep u_prep (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_adv                (w_adv),
        .i_cfg                (r_cfg),
        .i_valid              (i_in_valid),
        .i_obs_temperature    (i_obs_temperature),
        .i_obs_valid          (i_obs_valid),
        .i_station_height     (i_station_height),
        .i_station_valid      (i_station_valid),
        .i_model_height       (i_model_height),
        .i_model_valid        (i_model_valid),
        .i_lower_level_temp   (i_lower_level_temp),
        .i_upper_level_temp   (i_upper_level_temp),
        .i_lower_level_height (i_lower_level_height),
        .i_upper_level_height (i_upper_level_height),
        .i_profile_valid      (i_profile_valid),
        .o_valid              (w_valid[0]),
        .o_div                (w_div[0]),
        .o_side               (w_side[0])
    );

    // row of division cells, msb of the quotient first
    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        lrta_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_div   (w_div[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_div   (w_div[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // rate, correction and output register
    lrta_tail u_tail (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_adv                  (w_adv),
        .i_cfg                  (r_cfg),
        .i_valid                (w_valid[QUO_W]),
        .i_div                  (w_div[QUO_W]),
        .i_side                 (w_side[QUO_W]),
        .o_valid                (o_out_valid),
        .o_adjusted_temperature (o_adjusted_temperature),
        .o_result_valid         (o_result_valid)
    );

    // checks
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_valid) |-> (o_adjusted_temperature == '0))
        else $error("invalid result carries a non-zero temperature");

    a_temp_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_adjusted_temperature <= TEMP_MAX))
        else $error("adjusted temperature above 400 K");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while the result is held");

    a_lsb_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[QUO_W] && !w_adv) |=> $stable(w_div[QUO_W].quo))
        else $error("last division cell changed during a stall");

endmodule
